>>> hw/rtl/slsd_pkg.sv
`default_nettype none
package slsd_pkg;

  // Table depth default.
  localparam int TABLE_ENTRIES_DEF = 64;

  // Event kinds.
  localparam logic [1:0] KIND_INSTR = 2'd0;
  localparam logic [1:0] KIND_STORE = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME_GAP    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_REACH     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_AGE       = 8'd3;

  // Configuration reset values.
  localparam logic [3:0]  THRESHOLD_RST = 4'd6;
  localparam logic [31:0] MAX_GAP_RST   = 32'd20000;
  localparam logic [15:0] REACH_RST     = 16'd1024;
  localparam logic [31:0] STALE_RST     = 32'd100000;

  // Scoring limits.
  localparam logic [63:0] GAP_NEAR   = 64'd500;
  localparam logic [63:0] GAP_MID    = 64'd5000;
  localparam logic [6:0]  SIZE_SPILL = 7'd8;
  localparam logic [63:0] IDIST_NEAR = 64'd5;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic [63:0] address;
    logic [63:0] pc;
    logic [63:0] tick;
    logic [6:0]  size;
    logic [63:0] stack_pointer;
    logic [63:0] icount;
  } entry_t;

  // Scorer result.
  typedef struct packed {
    logic              done;
    logic signed [4:0] score;
  } score_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/store_load_spill_detector_unit.sv
`default_nettype none
// Retired-instruction events never raise busy.
// A store walks the table one entry per cycle, then writes its chosen slot.
// A load walks until its first hit or the last entry, then reports its result.
// The single read port of the entry memory sets the rate; one event at a time.
// Synchronous reset clears valid bits and counters and restores the configuration reset values; memory is not cleared.
module store_load_spill_detector_unit
  import slsd_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_kind,
  input  wire logic [63:0]          in_address,
  input  wire logic [63:0]          in_pc,
  input  wire logic [63:0]          in_tick,
  input  wire logic [6:0]           in_access_size,
  input  wire logic [63:0]          in_stack_pointer,
  output logic                      out_valid,
  output logic                      out_spill_found,
  output logic signed [4:0]         out_score,
  output logic [63:0]               out_store_pc,
  output logic [63:0]               out_store_tick,
  output logic [63:0]               out_store_instruction_count,
  output logic [63:0]               out_load_instruction_count,
  output logic [31:0]               out_spill_total,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W:0]   CNT_END  = (IDX_W+1)'(TABLE_ENTRIES);
  localparam logic [IDX_W:0]   CNT_ONE  = (IDX_W+1)'(1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_SCORE = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_WRITE = 5'b10000
  } state_t;

  state_t state_r;

  // Configuration.
  logic [3:0]  thr_r;
  logic [31:0] max_gap_r;
  logic [15:0] reach_r;
  logic [31:0] stale_r;

  // Counters.
  logic [63:0] icnt_r;
  logic [31:0] spill_cnt_r;

  // Latched event.
  logic        is_load_r;
  logic [63:0] addr_r;
  logic [63:0] pc_r;
  logic [63:0] tick_r;
  logic [6:0]  size_r;
  logic [63:0] sp_r;

  // Table memory and valid bits.
  entry_t                   mem [TABLE_ENTRIES];
  entry_t                   mem_q;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic                     mem_we;
  logic [IDX_W-1:0]         wr_idx;
  entry_t                   wr_data;

  // Scan pipeline.
  logic [IDX_W:0]   cnt_r;
  logic             pipe_vld_r;
  logic [IDX_W-1:0] pipe_idx_r;

  // Store trackers.
  logic                     match_found_r;
  logic [IDX_W-1:0]         match_idx_r;
  logic                     free_found_r;
  logic [IDX_W-1:0]         free_idx_r;
  logic                     stale_found_r;
  logic [IDX_W-1:0]         stale_idx_r;
  logic [TABLE_ENTRIES-1:0] stale_mask_r;
  logic [63:0]              best_age_r;
  logic [IDX_W-1:0]         best_idx_r;

  // Load hit.
  entry_t           hit_r;
  logic [IDX_W-1:0] hit_idx_r;

  score_res_t res;

  logic        accept;
  logic        hit;
  logic        ent_valid;
  logic [63:0] age;
  logic        spill;
  logic [IDX_W-1:0] slot;

  assign accept    = start && !busy;
  assign busy      = state_r != ST_IDLE;
  assign cfg_ready = 1'b1;
  assign ent_valid = valid_r[pipe_idx_r];
  assign hit       = ent_valid && (mem_q.address == addr_r);
  assign age       = tick_r - mem_q.tick;
  assign spill     = $signed({res.score[4], res.score}) >= $signed({2'b00, thr_r});

  // Slot chosen for a store.
  always_comb begin
    if (match_found_r) begin
      slot = match_idx_r;
    end else if (free_found_r) begin
      slot = free_idx_r;
    end else if (stale_found_r) begin
      slot = stale_idx_r;
    end else begin
      slot = best_idx_r;
    end
  end

  assign mem_we  = state_r == ST_WRITE;
  assign wr_idx  = slot;
  assign wr_data = '{address: addr_r, pc: pc_r, tick: tick_r, size: size_r,
                     stack_pointer: sp_r, icount: icnt_r};

  // Entry memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_data;
    end
    mem_q <= mem[cnt_r[IDX_W-1:0]];
  end

  // Configuration words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THRESHOLD_RST;
      max_gap_r <= MAX_GAP_RST;
      reach_r   <= REACH_RST;
      stale_r   <= STALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCORE_THRESHOLD: thr_r     <= cfg_data[3:0];
        REG_MAX_TIME_GAP:    max_gap_r <= cfg_data;
        REG_STACK_REACH:     reach_r   <= cfg_data[15:0];
        REG_STALE_AGE:       stale_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      icnt_r      <= '0;
      spill_cnt_r <= '0;
      out_valid   <= 1'b0;
      pipe_vld_r  <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_kind == KIND_INSTR) begin
              icnt_r <= icnt_r + 64'd1;
            end else if (in_kind == KIND_STORE || in_kind == KIND_LOAD) begin
              is_load_r     <= in_kind == KIND_LOAD;
              addr_r        <= in_address;
              pc_r          <= in_pc;
              tick_r        <= in_tick;
              size_r        <= in_access_size;
              sp_r          <= in_stack_pointer;
              cnt_r         <= '0;
              pipe_vld_r    <= 1'b0;
              match_found_r <= 1'b0;
              free_found_r  <= 1'b0;
              stale_found_r <= 1'b0;
              stale_mask_r  <= '0;
              state_r       <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // Issue the next read while the previous word is checked.
          pipe_vld_r <= cnt_r != CNT_END;
          pipe_idx_r <= cnt_r[IDX_W-1:0];
          if (cnt_r != CNT_END) begin
            cnt_r <= cnt_r + CNT_ONE;
          end
          if (pipe_vld_r) begin
            if (is_load_r) begin
              if (hit) begin
                hit_r     <= mem_q;
                hit_idx_r <= pipe_idx_r;
                state_r   <= ST_SCORE;
              end else if (pipe_idx_r == IDX_LAST) begin
                out_valid                   <= 1'b1;
                out_spill_found             <= 1'b0;
                out_score                   <= 5'sd0;
                out_store_pc                <= '0;
                out_store_tick              <= '0;
                out_store_instruction_count <= '0;
                out_load_instruction_count  <= icnt_r;
                out_spill_total             <= spill_cnt_r;
                state_r                     <= ST_IDLE;
              end
            end else begin
              if (hit && !match_found_r) begin
                match_found_r <= 1'b1;
                match_idx_r   <= pipe_idx_r;
              end
              if (!ent_valid && !free_found_r) begin
                free_found_r <= 1'b1;
                free_idx_r   <= pipe_idx_r;
              end
              if (age > {32'd0, stale_r}) begin
                stale_mask_r[pipe_idx_r] <= 1'b1;
                if (!stale_found_r) begin
                  stale_found_r <= 1'b1;
                  stale_idx_r   <= pipe_idx_r;
                end
              end
              if (pipe_idx_r == '0 || age > best_age_r) begin
                best_age_r <= age;
                best_idx_r <= pipe_idx_r;
              end
              if (pipe_idx_r == IDX_LAST) begin
                state_r <= ST_WRITE;
              end
            end
          end
        end
        ST_SCORE: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (res.done) begin
            out_valid                   <= 1'b1;
            out_spill_found             <= spill;
            out_score                   <= res.score;
            out_store_pc                <= hit_r.pc;
            out_store_tick              <= hit_r.tick;
            out_store_instruction_count <= hit_r.icount;
            out_load_instruction_count  <= icnt_r;
            if (spill) begin
              valid_r[hit_idx_r] <= 1'b0;
              if (spill_cnt_r != '1) begin
                spill_cnt_r     <= spill_cnt_r + 32'd1;
                out_spill_total <= spill_cnt_r + 32'd1;
              end else begin
                out_spill_total <= spill_cnt_r;
              end
            end else begin
              out_spill_total <= spill_cnt_r;
            end
            state_r <= ST_IDLE;
          end
        end
        ST_WRITE: begin
          // A full table without a match is purged of stale words first.
          if (!match_found_r && !free_found_r) begin
            valid_r       <= (valid_r & ~stale_mask_r) | (TABLE_ENTRIES'(1) << slot);
          end else begin
            valid_r[slot] <= 1'b1;
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  slsd_scorer u_scorer (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (state_r == ST_SCORE),
    .entry        (hit_r),
    .load_pc      (pc_r),
    .ld_tick      (tick_r),
    .icount       (icnt_r),
    .max_time_gap (max_gap_r),
    .stack_reach  (reach_r),
    .res          (res)
  );

`ifndef SYNTHESIS
  // A result word only follows a load.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> is_load_r)
    else $error("result word without a load");

  // The spill count never goes backwards.
  a_spill_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> spill_cnt_r >= $past(spill_cnt_r))
    else $error("spill count decreased");

  // An accepted store or load makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_kind == KIND_STORE || in_kind == KIND_LOAD) |=> busy)
    else $error("memory event not taken up");

  // The scorer only finishes while a load waits for it.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> state_r == ST_WAIT)
    else $error("scorer finished out of turn");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/slsd_scorer.sv
`default_nettype none
module slsd_scorer
  import slsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire entry_t      entry,
  input  wire logic [63:0] load_pc,
  input  wire logic [63:0] ld_tick,
  input  wire logic [63:0] icount,
  input  wire logic [31:0] max_time_gap,
  input  wire logic [15:0] stack_reach,
  output score_res_t       res
);

  logic        a_vld_r;
  logic [63:0] gap_r;
  logic [63:0] idist_r;
  logic [63:0] low_r;
  logic [63:0] addr_r;
  logic [63:0] sp_r;
  logic        pc_eq_r;
  logic        size8_r;
  logic        done_r;
  logic signed [4:0] score_r;
  logic signed [4:0] score_nxt;
  logic        zero;
  logic [2:0]  time_pts;
  logic        stack_hit;

  // First stage: the three wide differences.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start;
    end
    gap_r   <= ld_tick - entry.tick;
    idist_r <= icount - entry.icount;
    low_r   <= entry.stack_pointer - {48'd0, stack_reach};
    addr_r  <= entry.address;
    sp_r    <= entry.stack_pointer;
    pc_eq_r <= entry.pc == load_pc;
    size8_r <= entry.size == SIZE_SPILL;
  end

  // Second stage: compares and the sum of points.
  always_comb begin
    zero = (gap_r == 64'd0) || pc_eq_r || (idist_r == 64'd0);
    if (gap_r < GAP_NEAR) begin
      time_pts = 3'd3;
    end else if (gap_r < GAP_MID) begin
      time_pts = 3'd2;
    end else if (gap_r < {32'd0, max_time_gap}) begin
      time_pts = 3'd1;
    end else begin
      time_pts = 3'd0;
    end
    stack_hit = (sp_r != 64'd0) && (addr_r >= low_r) && (addr_r < sp_r);
    if (zero || time_pts == 3'd0) begin
      score_nxt = 5'sd0;
    end else begin
      score_nxt = $signed({2'b00, time_pts})
                + (stack_hit ? 5'sd4 : 5'sd0)
                + (size8_r ? 5'sd2 : 5'sd0)
                + ((idist_r < IDIST_NEAR) ? -5'sd2 : 5'sd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= a_vld_r;
    end
    score_r <= score_nxt;
  end

  assign res.done  = done_r;
  assign res.score = score_r;

endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import slsd_pkg::*;

  localparam int          DEPTH       = TABLE_ENTRIES_DEF;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int          SETTLE      = DEPTH + 20;

  // One reload report as the block should present it.
  typedef struct {
    logic              spill;
    logic signed [4:0] score;
    logic [63:0]       saved_pc;
    logic [63:0]       saved_tick;
    logic [63:0]       store_icount;
    logic [63:0]       load_icount;
    logic [31:0]       spill_total;
  } reload_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = '0;
  logic [63:0] in_address = '0;
  logic [63:0] in_pc = '0;
  logic [63:0] in_tick = '0;
  logic [6:0]  in_access_size = '0;
  logic [63:0] in_stack_pointer = '0;
  logic        out_valid;
  logic        out_spill_found;
  logic signed [4:0] out_score;
  logic [63:0] out_store_pc;
  logic [63:0] out_store_tick;
  logic [63:0] out_store_instruction_count;
  logic [63:0] out_load_instruction_count;
  logic [31:0] out_spill_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  store_load_spill_detector_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_address(in_address), .in_pc(in_pc), .in_tick(in_tick),
    .in_access_size(in_access_size), .in_stack_pointer(in_stack_pointer),
    .out_valid(out_valid), .out_spill_found(out_spill_found), .out_score(out_score),
    .out_store_pc(out_store_pc), .out_store_tick(out_store_tick),
    .out_store_instruction_count(out_store_instruction_count),
    .out_load_instruction_count(out_load_instruction_count),
    .out_spill_total(out_spill_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the configuration and of the store table.
  logic [3:0]  thr_q;
  logic [31:0] max_gap_q;
  logic [15:0] reach_q;
  logic [31:0] stale_q;
  bit          tbl_valid [DEPTH];
  logic [63:0] tbl_addr [DEPTH];
  logic [63:0] tbl_pc [DEPTH];
  logic [63:0] tbl_tick [DEPTH];
  logic [6:0]  tbl_size [DEPTH];
  logic [63:0] tbl_sp [DEPTH];
  logic [63:0] tbl_icount [DEPTH];
  logic [63:0] icount_q;
  logic [31:0] spills_q;

  reload_t pending_reloads[$];
  int      mismatches;
  bit      failed;

  // Event generator state.
  logic [63:0] tick_now;
  logic [63:0] addr_pool [96];
  logic [63:0] pc_pool [8];

  function automatic int lookup_slot(logic [63:0] addr);
    for (int i = 0; i < DEPTH; i++)
      if (tbl_valid[i] && tbl_addr[i] == addr) return i;
    return -1;
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < DEPTH; i++)
      if (!tbl_valid[i]) return i;
    return -1;
  endfunction

  // Table update for a store: same address, free slot, stale purge, then oldest.
  function automatic void record_store(logic [63:0] addr, logic [63:0] pc,
                                       logic [63:0] tick, logic [6:0] size,
                                       logic [63:0] sp);
    int          slot;
    logic [63:0] oldest;
    logic [63:0] age;
    slot = lookup_slot(addr);
    if (slot < 0) slot = first_free_slot();
    if (slot < 0) begin
      for (int i = 0; i < DEPTH; i++)
        if (tick - tbl_tick[i] > {32'd0, stale_q}) tbl_valid[i] = 1'b0;
      slot = first_free_slot();
    end
    if (slot < 0) begin
      oldest = '0;
      slot = 0;
      for (int i = 0; i < DEPTH; i++) begin
        age = tick - tbl_tick[i];
        if (i == 0 || age > oldest) begin
          oldest = age;
          slot = i;
        end
      end
    end
    tbl_valid[slot]  = 1'b1;
    tbl_addr[slot]   = addr;
    tbl_pc[slot]     = pc;
    tbl_tick[slot]   = tick;
    tbl_size[slot]   = size;
    tbl_sp[slot]     = sp;
    tbl_icount[slot] = icount_q;
  endfunction

  // Spill score in whole points for a load that hit slot e.
  function automatic int grade_reload(int e, logic [63:0] pc, logic [63:0] tick);
    logic [63:0] gap;
    logic [63:0] icnt_gap;
    logic [63:0] sp;
    int          s;
    gap      = tick - tbl_tick[e];
    icnt_gap = icount_q - tbl_icount[e];
    sp       = tbl_sp[e];
    if (gap == 0 || tbl_pc[e] == pc || icnt_gap == 0) return 0;
    if (gap < 64'd500) s = 3;
    else if (gap < 64'd5000) s = 2;
    else if (gap < {32'd0, max_gap_q}) s = 1;
    else return 0;
    if (sp != 0 && tbl_addr[e] >= sp - {48'd0, reach_q} && tbl_addr[e] < sp) s += 4;
    if (tbl_size[e] == 7'd8) s += 2;
    if (icnt_gap < 64'd5) s -= 2;
    else s += 1;
    return s;
  endfunction

  function automatic reload_t judge_load(logic [63:0] addr, logic [63:0] pc,
                                         logic [63:0] tick);
    reload_t r;
    int      e;
    int      s;
    r = '{1'b0, 5'sd0, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0};
    e = lookup_slot(addr);
    if (e >= 0) begin
      s = grade_reload(e, pc, tick);
      r.score        = s[4:0];
      r.saved_pc     = tbl_pc[e];
      r.saved_tick   = tbl_tick[e];
      r.store_icount = tbl_icount[e];
      if (s >= int'(thr_q)) begin
        r.spill = 1'b1;
        tbl_valid[e] = 1'b0;
        if (spills_q != 32'hFFFF_FFFF) spills_q++;
      end
    end
    r.load_icount = icount_q;
    r.spill_total = spills_q;
    return r;
  endfunction

  // Sends one event word and updates the shadow state once it is taken.
  task automatic send_event(logic [1:0] kind, logic [63:0] addr, logic [63:0] pc,
                            logic [63:0] tick, logic [6:0] size, logic [63:0] sp);
    int r;
    int gap;
    start            <= 1'b1;
    in_kind          <= kind;
    in_address       <= addr;
    in_pc            <= pc;
    in_tick          <= tick;
    in_access_size   <= size;
    in_stack_pointer <= sp;
    do @(posedge clk); while (busy);
    case (kind)
      KIND_INSTR: icount_q++;
      KIND_STORE: record_store(addr, pc, tick, size, sp);
      KIND_LOAD:  pending_reloads = {pending_reloads, judge_load(addr, pc, tick)};
      default: ;
    endcase
    r = $urandom_range(0, 99);
    if (r < 60) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 4);
    else gap = $urandom_range(20, 150);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic halt_sender();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every reload word has arrived and a store walk would be over.
  task automatic drain();
    halt_sender();
    while (pending_reloads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SCORE_THRESHOLD: thr_q     = data[3:0];
      REG_MAX_TIME_GAP:    max_gap_q = data;
      REG_STACK_REACH:     reach_q   = data[15:0];
      REG_STALE_AGE:       stale_q   = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] thr, logic [31:0] gap, logic [31:0] reach,
                           logic [31:0] stale);
    drain();
    write_reg(REG_SCORE_THRESHOLD, thr);
    write_reg(REG_MAX_TIME_GAP, gap);
    write_reg(REG_STACK_REACH, reach);
    write_reg(REG_STALE_AGE, stale);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Moves simulated time on, mostly in steps that land in each time band.
  function automatic logic [63:0] next_tick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) tick_now += $urandom_range(1, 499);
    else if (r < 80) tick_now += $urandom_range(500, 6000);
    else if (r < 95) tick_now += $urandom_range(6000, 40000);
    else if (r < 98) tick_now += 0;
    else tick_now = rand64();
    return tick_now;
  endfunction

  // One random event drawn from the first npool addresses of the pool.
  task automatic random_event(int npool);
    int          r;
    logic [63:0] addr;
    logic [63:0] pc;
    logic [63:0] sp;
    logic [63:0] tick;
    logic [6:0]  size;
    addr = addr_pool[$urandom_range(0, npool - 1)];
    pc   = ($urandom_range(0, 3) == 0) ? pc_pool[$urandom_range(0, 7)] : rand64();
    tick = next_tick();
    r = $urandom_range(0, 99);
    if (r < 40) sp = addr + $urandom_range(1, 1500);
    else if (r < 60) sp = '0;
    else if (r < 65) sp = '1;
    else sp = rand64();
    size = ($urandom_range(0, 1) == 0) ? 7'd8 : 7'($urandom_range(0, 64));
    r = $urandom_range(0, 99);
    if (r < 40) send_event(KIND_INSTR, rand64(), rand64(), rand64(), 7'($urandom),
                           rand64());
    else if (r < 68) send_event(KIND_STORE, addr, pc, tick, size, sp);
    else if (r < 97) begin
      // Now and then a load is stamped before the store it meets.
      if ($urandom_range(0, 19) == 0) tick = tick - $urandom_range(1, 1000);
      send_event(KIND_LOAD, addr, pc, tick, size, sp);
    end else send_event(KIND_UNUSED, addr, pc, tick, size, sp);
  endtask

  // Hand-picked events: band edges, extremes, negative score and ignored kind.
  task automatic test_directed();
    logic [63:0] a;
    a = 64'h0000_7fff_ffff_e000;
    send_event(KIND_LOAD, a, 64'h10, 64'd100, 7'd8, 64'd0);
    send_event(KIND_STORE, a, 64'h400, 64'd1000, 7'd8, a + 64'd16);
    send_event(KIND_LOAD, a, 64'h400, 64'd1100, 7'd8, 64'd0);
    send_event(KIND_INSTR, '0, '0, '0, '0, '0);
    send_event(KIND_LOAD, a, 64'h404, 64'd1200, 7'd8, 64'd0);
    repeat (6) send_event(KIND_INSTR, '1, '1, '1, 7'h7f, '1);
    send_event(KIND_LOAD, a, 64'h408, 64'd1499, 7'd8, 64'd0);
    send_event(KIND_LOAD, a, 64'h408, 64'd1600, 7'd8, 64'd0);
    send_event(KIND_STORE, '1, '1, 64'd10000, 7'd64, '1);
    send_event(KIND_INSTR, '0, '0, '0, '0, '0);
    send_event(KIND_LOAD, '1, 64'h1, 64'd9000, 7'd0, '0);
    send_event(KIND_LOAD, '1, 64'h1, 64'd14999, 7'd0, '0);
    send_event(KIND_LOAD, '1, 64'h1, 64'd15000, 7'd0, '0);
    send_event(KIND_LOAD, '1, 64'h1, 64'd29999, 7'd0, '0);
    send_event(KIND_LOAD, '1, 64'h1, 64'd30000, 7'd0, '0);
    send_event(KIND_STORE, 64'd0, 64'h2, '1, 7'd0, 64'd0);
    send_event(KIND_INSTR, '0, '0, '0, '0, '0);
    send_event(KIND_LOAD, 64'd0, 64'h3, 64'd3, 7'd8, '1);
    send_event(KIND_UNUSED, 64'd0, 64'h3, 64'd4, 7'd8, '1);
    send_event(KIND_LOAD, 64'd0, 64'h3, 64'd400, 7'd64, '1);
    drain();
  endtask

  // Overfills the table with old and fresh stores to reach purge and eviction.
  task automatic test_table_full();
    logic [63:0] base;
    base = rand64();
    write_all(6, 20000, 1024, 32'hFFFF_FFFF);
    for (int i = 0; i < DEPTH + 8; i++)
      send_event(KIND_STORE, base + 64'(i * 8), rand64(), 64'(1000 + i * 7), 7'd8,
                 base + 64'd1024);
    send_event(KIND_INSTR, '0, '0, '0, '0, '0);
    for (int i = 0; i < 6; i++)
      send_event(KIND_LOAD, base + 64'(i * 16), rand64(), 64'd1700, 7'd8, '0);
    write_all(6, 20000, 1024, 5000);
    for (int i = 0; i < 10; i++)
      send_event(KIND_STORE, base + 64'(4096 + i * 8), rand64(), 64'(7000 + i),
                 7'd4, '0);
    send_event(KIND_INSTR, '0, '0, '0, '0, '0);
    for (int i = 0; i < 6; i++)
      send_event(KIND_LOAD, base + 64'(4096 + i * 8), rand64(), 64'd7200, 7'd8, '0);
    drain();
  endtask

  // Traffic under several register settings, the extremes among them.
  task automatic test_config_sweep();
    logic [31:0] sets [6][4];
    sets = '{'{0, 1, 0, 1},
             '{10, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF},
             '{32'hFFFF_FFF7, 6000, 32'hFFFF_0800, 50000},
             '{3, 4999, 1, 2},
             '{$urandom_range(0, 10), $urandom_range(1, 60000), $urandom_range(0, 65535),
               $urandom_range(1, 200000)},
             '{6, 20000, 1024, 100000}};
    for (int s = 0; s < 6; s++) begin
      write_all(sets[s][0], sets[s][1], sets[s][2], sets[s][3]);
      repeat (55) random_event(96);
    end
    drain();
  endtask

  // Long random run with one full pause in the middle.
  task automatic test_random_traffic();
    repeat (150) random_event(48);
    drain();
    repeat (150) random_event(96);
    drain();
  endtask

  // Compares every reload word against the oldest prediction.
  always @(posedge clk) begin
    reload_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_reloads.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected reload word, score %0d", out_score);
      end else begin
        exp_r = pending_reloads.pop_front();
        if (out_spill_found !== exp_r.spill || out_score !== exp_r.score ||
            out_store_pc !== exp_r.saved_pc || out_store_tick !== exp_r.saved_tick ||
            out_store_instruction_count !== exp_r.store_icount ||
            out_load_instruction_count !== exp_r.load_icount ||
            out_spill_total !== exp_r.spill_total) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) begin
            $display("reload mismatch: exp spill %0d score %0d pc %h tick %h ic %h/%h tot %0d",
                     exp_r.spill, exp_r.score, exp_r.saved_pc, exp_r.saved_tick,
                     exp_r.store_icount, exp_r.load_icount, exp_r.spill_total);
            $display("                 got spill %0d score %0d pc %h tick %h ic %h/%h tot %0d",
                     out_spill_found, out_score, out_store_pc, out_store_tick,
                     out_store_instruction_count, out_load_instruction_count,
                     out_spill_total);
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    thr_q = THRESHOLD_RST;
    max_gap_q = MAX_GAP_RST;
    reach_q = REACH_RST;
    stale_q = STALE_RST;
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
    icount_q = '0;
    spills_q = '0;
    mismatches = 0;
    failed = 1'b0;
    tick_now = 64'd50000;
    for (int i = 0; i < 96; i++) addr_pool[i] = rand64();
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 0; i < 8; i++) pc_pool[i] = rand64();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_config_sweep();
    test_random_traffic();
    if (pending_reloads.size() != 0) failed = 1'b1;
    if (!failed) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/slsd_pkg.sv
hw/rtl/slsd_scorer.sv
hw/rtl/store_load_spill_detector_unit.sv
dv/testbench.sv
